FILE: rtl/core/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared sizes, codes, types and helpers for the linear probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    // table geometry
    localparam int SLOTS     = 13;
    localparam int KEY_BITS  = 16;
    localparam int SLOT_BITS = $clog2(SLOTS);

    // field widths of the result
    localparam int OUT_SLOT_W = 4;
    localparam int STATUS_W   = 2;
    localparam int OP_W       = 2;

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // home slot folding: key is split into nibbles, each weighted by 16^i mod SLOTS
    localparam int NIB       = (KEY_BITS + 3) / 4;
    localparam int KEY_PAD_W = NIB * 4;
    localparam int SUM_MAX   = NIB * 15 * (SLOTS - 1);
    localparam int SUM_W     = $clog2(SUM_MAX + 1);
    localparam int QB        = $clog2(NIB * 15 + 1);
    localparam int RED_W     = SUM_W + 2;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [SLOT_BITS-1:0]  t_idx;
    typedef logic [OUT_SLOT_W-1:0] t_oslot;
    typedef logic [KEY_PAD_W-1:0]  t_kpad;
    typedef logic [SUM_W-1:0]      t_sum;
    typedef logic [RED_W-1:0]      t_red;

    typedef struct packed {
        logic [OP_W-1:0] op;
        t_key            key;
        t_idx            home;
    } t_cmd;

    // weight of nibble idx: 16^idx mod SLOTS
    function automatic int nib_weight(input int idx);
        int w;
        w = 1;
        for (int j = 0; j < idx; j++) begin
            w = (w * 16) % SLOTS;
        end
        return w;
    endfunction

endpackage

FILE: rtl/core/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 13
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/lpht_front.sv
// ----------------------------------------------------------------------------
// lpht_front
// Accepts requests, folds the key into its home slot and queues the command.
// ----------------------------------------------------------------------------
module lpht_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [lpht_pkg::OP_W-1:0]          i_op,
    input  lpht_pkg::t_key                     i_key,
    output logic                               o_full,
    input  logic                               i_q_full,
    output logic                               o_q_push,
    output lpht_pkg::t_cmd                     o_q_cmd
);

    logic                      r_vld, n_vld;
    logic [lpht_pkg::OP_W-1:0] r_op;
    lpht_pkg::t_key            r_key;
    lpht_pkg::t_sum            r_sum, n_sum;
    lpht_pkg::t_kpad           kpad;
    lpht_pkg::t_red            red;
    logic                      accept;

    assign o_full   = r_vld & i_q_full;
    assign accept   = i_push & ~o_full;
    assign o_q_push = r_vld & ~i_q_full;

    // weighted nibble sum, congruent to the key modulo the table size
    always_comb begin
        kpad  = lpht_pkg::t_kpad'(i_key);
        n_sum = '0;
        for (int i = 0; i < lpht_pkg::NIB; i++) begin
            n_sum = n_sum + lpht_pkg::t_sum'(kpad[4*i +: 4])
                          * lpht_pkg::t_sum'(lpht_pkg::nib_weight(i));
        end
    end

    // reduce the folded sum below the table size by shifted subtraction
    always_comb begin
        red = lpht_pkg::t_red'(r_sum);
        for (int j = lpht_pkg::QB - 1; j >= 0; j--) begin
            if (red >= (lpht_pkg::t_red'(lpht_pkg::SLOTS) << j)) begin
                red = red - (lpht_pkg::t_red'(lpht_pkg::SLOTS) << j);
            end
        end
    end

    assign o_q_cmd.op   = r_op;
    assign o_q_cmd.key  = r_key;
    assign o_q_cmd.home = red[lpht_pkg::SLOT_BITS-1:0];

    // holding register valid
    always_comb begin
        n_vld = r_vld;
        if (accept) begin
            n_vld = 1'b1;
        end else if (o_q_push) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // request payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_op;
            r_key <= i_key;
            r_sum <= n_sum;
        end
    end

endmodule

FILE: rtl/core/lpht_fifo.sv
// ----------------------------------------------------------------------------
// lpht_fifo
// Short command queue that decouples the front from the probe engine.
// ----------------------------------------------------------------------------
module lpht_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lpht_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output lpht_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    lpht_pkg::t_cmd                r_mem [lpht_pkg::QDEPTH];
    logic [lpht_pkg::QPTR_W-1:0]   r_wr, n_wr;
    logic [lpht_pkg::QPTR_W-1:0]   r_rd, n_rd;
    logic [lpht_pkg::QCNT_W-1:0]   r_cnt, n_cnt;
    logic                          do_push, do_pop;

    assign o_full  = (r_cnt == lpht_pkg::QCNT_W'(lpht_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;
    assign o_cmd   = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == lpht_pkg::QPTR_W'(lpht_pkg::QDEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == lpht_pkg::QPTR_W'(lpht_pkg::QDEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/core/lpht_back.sv
// ----------------------------------------------------------------------------
// lpht_back
// Probe engine: walks the table one slot at a time and holds the result.
// ----------------------------------------------------------------------------
module lpht_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lpht_pkg::t_cmd i_cmd,
    input  logic           i_q_empty,
    output logic           o_q_pop,
    output logic           o_empty,
    input  logic           i_pop,
    output lpht_pkg::t_oslot                  o_slot,
    output logic [lpht_pkg::STATUS_W-1:0]     o_status
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_INS  = 4'b0010,
        S_RD   = 4'b0100,
        S_CMP  = 4'b1000
    } t_state;

    localparam lpht_pkg::t_idx LAST = lpht_pkg::t_idx'(lpht_pkg::SLOTS - 1);

    t_state                          r_state, n_state;
    logic [lpht_pkg::SLOTS-1:0]      r_used, n_used;
    lpht_pkg::t_idx                  r_idx, n_idx;
    lpht_pkg::t_idx                  r_cnt, n_cnt;
    lpht_pkg::t_key                  r_key, n_key;
    logic                            r_out_vld, n_out_vld;
    lpht_pkg::t_oslot                r_out_slot, n_out_slot;
    logic [lpht_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    logic                            out_free;
    logic                            emit;
    lpht_pkg::t_oslot                emit_slot;
    logic [lpht_pkg::STATUS_W-1:0]   emit_status;
    logic                            ram_we, ram_re;
    lpht_pkg::t_key                  ram_rdata;
    lpht_pkg::t_idx                  idx_next;

    assign out_free = ~r_out_vld | i_pop;
    assign idx_next = (r_idx == LAST) ? '0 : r_idx + 1'b1;

    // stored keys
    lpht_ram #(
        .WIDTH (lpht_pkg::KEY_BITS),
        .DEPTH (lpht_pkg::SLOTS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_key),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // probe sequencer
    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_key       = r_key;
        o_q_pop     = 1'b0;
        emit        = 1'b0;
        emit_slot   = '0;
        emit_status = lpht_pkg::ST_DONE;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    case (i_cmd.op)
                        lpht_pkg::OP_INSERT: begin
                            o_q_pop = 1'b1;
                            n_key   = i_cmd.key;
                            n_idx   = i_cmd.home;
                            n_cnt   = '0;
                            n_state = S_INS;
                        end
                        lpht_pkg::OP_SEARCH: begin
                            o_q_pop = 1'b1;
                            n_key   = i_cmd.key;
                            n_idx   = i_cmd.home;
                            n_cnt   = '0;
                            n_state = S_RD;
                        end
                        default: begin
                            // clear or unused code: answer at once
                            if (out_free) begin
                                o_q_pop = 1'b1;
                                emit    = 1'b1;
                                if (i_cmd.op == lpht_pkg::OP_CLEAR) begin
                                    n_used = '0;
                                end
                            end
                        end
                    endcase
                end
            end
            S_INS: begin
                if (!r_used[r_idx]) begin
                    if (out_free) begin
                        ram_we        = 1'b1;
                        n_used[r_idx] = 1'b1;
                        emit          = 1'b1;
                        emit_slot     = lpht_pkg::t_oslot'(r_idx);
                        n_state       = S_IDLE;
                    end
                end else if (r_cnt == LAST) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = lpht_pkg::ST_FULL;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_idx = idx_next;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_RD: begin
                if (!r_used[r_idx]) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = lpht_pkg::ST_MISS;
                        n_state     = S_IDLE;
                    end
                end else begin
                    ram_re  = 1'b1;
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (ram_rdata == r_key) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_slot   = lpht_pkg::t_oslot'(r_idx);
                        emit_status = lpht_pkg::ST_FOUND;
                        n_state     = S_IDLE;
                    end
                end else if (r_cnt == LAST) begin
                    if (out_free) begin
                        emit        = 1'b1;
                        emit_status = lpht_pkg::ST_MISS;
                        n_state     = S_IDLE;
                    end
                end else begin
                    n_idx   = idx_next;
                    n_cnt   = r_cnt + 1'b1;
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        n_out_vld    = r_out_vld;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        if (emit) begin
            n_out_vld    = 1'b1;
            n_out_slot   = emit_slot;
            n_out_status = emit_status;
        end else if (i_pop) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_cnt        <= n_cnt;
        r_key        <= n_key;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
    end

    assign o_empty  = ~r_out_vld;
    assign o_slot   = r_out_slot;
    assign o_status = r_out_status;

endmodule

FILE: rtl/core/linear_probe_hash_table_top.sv
// A request passes through the front holding register and the command queue
// into the probe engine, which registers the result. The probe engine handles
// one request at a time, one slot per cycle on insert, and on search a read
// state and a compare state per slot (registered key read); further requests
// wait in the front and the queue while the engine is busy.
// Reset is synchronous: queues empty, every slot empty, stored keys unchanged.
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open addressing hash table with linear probing: clear, insert, search.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [lpht_pkg::OP_W-1:0]        i_op,
    input  lpht_pkg::t_key                   i_key,
    output logic                             empty,
    input  logic                             pop,
    output lpht_pkg::t_oslot                 o_slot,
    output logic [lpht_pkg::STATUS_W-1:0]    o_status
);

    logic           q_push, q_full, q_pop, q_empty;
    lpht_pkg::t_cmd q_in, q_out;

    // request intake and home slot
    lpht_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_op     (i_op),
        .i_key    (i_key),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in)
    );

    // command queue
    lpht_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_cmd   (q_out),
        .o_empty (q_empty)
    );

    // probe engine and result register
    lpht_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_out),
        .i_q_empty (q_empty),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_slot    (o_slot),
        .o_status  (o_status)
    );

endmodule

FILE: rtl/core/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port level checks on the hash table result stream.
// ----------------------------------------------------------------------------
module lpht_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input lpht_pkg::t_oslot               o_slot,
    input logic [lpht_pkg::STATUS_W-1:0]  o_status
);

    // no result left over after reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result visible after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_slot) && $stable(o_status)))
        else $error("waiting result changed");

    // a reported slot lies inside the table
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (int'(o_slot) < lpht_pkg::SLOTS))
        else $error("slot out of range");

    // misses and full-table reports carry slot zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == lpht_pkg::ST_MISS || o_status == lpht_pkg::ST_FULL))
        |-> (o_slot == '0))
        else $error("nonzero slot on miss or full");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .push     (push),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_slot   (o_slot),
    .o_status (o_status)
);
